[sv/assert_macros.svh]
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LPR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LPR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/lpr_pkg.sv]
// Shared types and constants of the LRU page replacement core.
// No dependencies; used by the interfaces, the cell and the top level.
package lpr_pkg;

   localparam int FRAMES_DEFAULT = 8;
   localparam int PAGE_W         = 8;
   localparam int STAMP_W        = 32;
   localparam int COUNT_W        = 32;
   localparam int CSR_W          = 4;
   localparam int FRAME_IDX_W    = 3;

   localparam logic [CSR_W-1:0]   CSR_RESET = CSR_W'(8);
   localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } lpr_state_type;

   typedef struct packed {
      logic               valid;
      logic [PAGE_W-1:0]  page;
      logic               found;
      logic [STAMP_W-1:0] best_stamp;
      logic               best_valid;
      logic [PAGE_W-1:0]  best_page;
   } lpr_token_type;

   typedef struct packed {
      logic               en;
      logic               load;
      logic [PAGE_W-1:0]  page;
      logic [STAMP_W-1:0] stamp;
   } lpr_update_type;

endpackage

[sv/lpr_if.sv]
// Valid/ready channel interfaces for page references and replacement results.
// Depends on lpr_pkg for field widths.
interface lpr_req_if;
   logic                      valid;
   logic                      ready;
   logic [lpr_pkg::PAGE_W-1:0] page_id;

   modport source (output valid, output page_id, input ready);
   modport sink   (input valid, input page_id, output ready);
endinterface

interface lpr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             hit;
   logic [lpr_pkg::FRAME_IDX_W-1:0]  frame_index;
   logic                             evicted_valid;
   logic [lpr_pkg::PAGE_W-1:0]       evicted_page;
   logic [lpr_pkg::COUNT_W-1:0]      fault_count;
   logic                             stamp_saturated;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output fault_count, output stamp_saturated,
                   input ready);
   modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                   input evicted_page, input fault_count, input stamp_saturated,
                   output ready);
endinterface

[sv/lpr_cell.sv]
// One page frame: page, valid bit and last-use stamp, plus one stage of the search token.
// Depends on lpr_pkg; instantiated in a row by lru_page_replacement_core.
module lpr_cell #(
   parameter int FRAMES   = lpr_pkg::FRAMES_DEFAULT,
   parameter int CELL_IDX = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [$clog2(FRAMES+1)-1:0]         n_eff,
   input  lpr_pkg::lpr_token_type              tok_i,
   input  logic [(FRAMES>1 ? $clog2(FRAMES) : 1)-1:0] hit_idx_i,
   input  logic [(FRAMES>1 ? $clog2(FRAMES) : 1)-1:0] best_idx_i,
   output lpr_pkg::lpr_token_type              tok_o,
   output logic [(FRAMES>1 ? $clog2(FRAMES) : 1)-1:0] hit_idx_o,
   output logic [(FRAMES>1 ? $clog2(FRAMES) : 1)-1:0] best_idx_o,
   input  lpr_pkg::lpr_update_type             upd_i,
   input  logic [(FRAMES>1 ? $clog2(FRAMES) : 1)-1:0] upd_idx_i
);
   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic [lpr_pkg::PAGE_W-1:0]  page_ff;
   logic                        valid_ff;
   logic [lpr_pkg::STAMP_W-1:0] stamp_ff;

   lpr_pkg::lpr_token_type tok_ff, tok_in;
   logic [IDX_W-1:0]       hit_ff, hit_in;
   logic [IDX_W-1:0]       best_ff, best_in;
   logic                   cell_on;

   assign cell_on = (CNT_W'(CELL_IDX) < n_eff);

   always_comb begin
      tok_in  = tok_i;
      hit_in  = hit_idx_i;
      best_in = best_idx_i;
      if (cell_on) begin
         if (!tok_i.found && valid_ff && (page_ff == tok_i.page)) begin
            tok_in.found = 1'b1;
            hit_in       = MY_IDX;
         end
         if (stamp_ff <= tok_i.best_stamp) begin
            tok_in.best_stamp = stamp_ff;
            tok_in.best_valid = valid_ff;
            tok_in.best_page  = page_ff;
            best_in           = MY_IDX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
      hit_ff  <= hit_in;
      best_ff <= best_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         stamp_ff <= '0;
      end else if (upd_i.en && (upd_idx_i == MY_IDX)) begin
         stamp_ff <= upd_i.stamp;
         if (upd_i.load) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd_i.en && upd_i.load && (upd_idx_i == MY_IDX)) begin
         page_ff <= upd_i.page;
      end
   end

   assign tok_o      = tok_ff;
   assign hit_idx_o  = hit_ff;
   assign best_idx_o = best_ff;

endmodule

[sv/lru_page_replacement_core.sv]
// LRU page replacement core: a row of FRAMES frame cells searched by a token, one cell a cycle.
// A new reference is taken only when idle: after the token has walked the cell row
// and the result of the last reference has been loaded into the output register.
// Reset (synchronous): frames invalid, stamps and counters zero, frames_in_use 8; no clear pass.
// Depends on lpr_pkg, lpr_if and lpr_cell.
module lru_page_replacement_core #(
   parameter int FRAMES = lpr_pkg::FRAMES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [lpr_pkg::CSR_W-1:0]   csr_wdata,
   lpr_req_if.sink                     req_port,
   lpr_rsp_if.source                   rsp_port
);
   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W = $clog2(FRAMES + 1);

   lpr_pkg::lpr_state_type state_ff, state_in;

   logic [lpr_pkg::CSR_W-1:0]   csr_ff;
   logic [lpr_pkg::STAMP_W-1:0] time_ff;
   logic [lpr_pkg::COUNT_W-1:0] faults_ff, faults_in;
   lpr_pkg::lpr_token_type      tok0_ff;
   lpr_pkg::lpr_token_type      res_ff;
   logic [IDX_W-1:0]            res_hit_ff;
   logic [IDX_W-1:0]            res_best_ff;

   logic                                rsp_valid_ff;
   logic                                rsp_hit_ff;
   logic [lpr_pkg::FRAME_IDX_W-1:0]     rsp_frame_ff;
   logic                                rsp_ev_valid_ff;
   logic [lpr_pkg::PAGE_W-1:0]          rsp_ev_page_ff;
   logic [lpr_pkg::COUNT_W-1:0]         rsp_faults_ff;
   logic                                rsp_sat_ff;

   lpr_pkg::lpr_token_type tok_w  [0:FRAMES];
   logic [IDX_W-1:0]       hit_w  [0:FRAMES];
   logic [IDX_W-1:0]       best_w [0:FRAMES];

   lpr_pkg::lpr_update_type upd;
   logic [IDX_W-1:0]        upd_idx;
   logic [CNT_W-1:0]        n_eff;
   logic                    accept;
   logic                    capture;
   logic                    finish;
   logic                    rsp_free;

   assign accept   = req_port.valid && req_port.ready;
   assign rsp_free = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      if (csr_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(csr_ff) > FRAMES) begin
         n_eff = CNT_W'(FRAMES);
      end else begin
         n_eff = CNT_W'(csr_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpr_pkg::ST_IDLE: if (req_port.valid) state_in = lpr_pkg::ST_SCAN;
         lpr_pkg::ST_SCAN: if (tok_w[FRAMES].valid) state_in = lpr_pkg::ST_DONE;
         lpr_pkg::ST_DONE: if (rsp_free) state_in = lpr_pkg::ST_IDLE;
         default:          state_in = lpr_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_port.ready = 1'b0;
      capture        = 1'b0;
      finish         = 1'b0;
      unique case (state_ff)
         lpr_pkg::ST_IDLE: req_port.ready = 1'b1;
         lpr_pkg::ST_SCAN: capture = tok_w[FRAMES].valid;
         lpr_pkg::ST_DONE: finish = rsp_free;
         default: begin
         end
      endcase
   end

   always_comb begin
      upd.en    = finish;
      upd.load  = !res_ff.found;
      upd.page  = res_ff.page;
      upd.stamp = time_ff;
      upd_idx   = res_ff.found ? res_hit_ff : res_best_ff;
      faults_in = faults_ff;
      if (!res_ff.found && (faults_ff != lpr_pkg::COUNT_MAX)) begin
         faults_in = faults_ff + 1'b1;
      end
   end

   assign tok_w[0]  = tok0_ff;
   assign hit_w[0]  = '0;
   assign best_w[0] = '0;

   for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      lpr_cell #(
         .FRAMES   (FRAMES),
         .CELL_IDX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .n_eff      (n_eff),
         .tok_i      (tok_w[g]),
         .hit_idx_i  (hit_w[g]),
         .best_idx_i (best_w[g]),
         .tok_o      (tok_w[g+1]),
         .hit_idx_o  (hit_w[g+1]),
         .best_idx_o (best_w[g+1]),
         .upd_i      (upd),
         .upd_idx_i  (upd_idx)
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpr_pkg::ST_IDLE;
         csr_ff       <= lpr_pkg::CSR_RESET;
         time_ff      <= '0;
         faults_ff    <= '0;
         tok0_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
         tok0_ff.valid <= accept;
         if (accept) begin
            if (time_ff != lpr_pkg::STAMP_MAX) begin
               time_ff <= time_ff + 1'b1;
            end
            tok0_ff.page       <= req_port.page_id;
            tok0_ff.found      <= 1'b0;
            tok0_ff.best_stamp <= lpr_pkg::STAMP_MAX;
            tok0_ff.best_valid <= 1'b0;
            tok0_ff.best_page  <= '0;
         end
         if (finish) begin
            faults_ff    <= faults_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         res_ff      <= tok_w[FRAMES];
         res_hit_ff  <= hit_w[FRAMES];
         res_best_ff <= best_w[FRAMES];
      end
      if (finish) begin
         rsp_hit_ff      <= res_ff.found;
         rsp_frame_ff    <= lpr_pkg::FRAME_IDX_W'(upd_idx);
         rsp_ev_valid_ff <= !res_ff.found && res_ff.best_valid;
         rsp_ev_page_ff  <= (!res_ff.found && res_ff.best_valid) ? res_ff.best_page : '0;
         rsp_faults_ff   <= faults_in;
         rsp_sat_ff      <= (time_ff == lpr_pkg::STAMP_MAX);
      end
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.hit             = rsp_hit_ff;
   assign rsp_port.frame_index     = rsp_frame_ff;
   assign rsp_port.evicted_valid   = rsp_ev_valid_ff;
   assign rsp_port.evicted_page    = rsp_ev_page_ff;
   assign rsp_port.fault_count     = rsp_faults_ff;
   assign rsp_port.stamp_saturated = rsp_sat_ff;

endmodule

[sv/lpr_checker.sv]
// Port-level checks on the result channel of lru_page_replacement_core, bound to the top.
// Depends on lpr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              hit,
   input logic                              evicted_valid,
   input logic [lpr_pkg::PAGE_W-1:0]        evicted_page,
   input logic [lpr_pkg::COUNT_W-1:0]       fault_count,
   input logic                              stamp_saturated
);
   logic                        seen_ff;
   logic                        sat_ff;
   logic [lpr_pkg::COUNT_W-1:0] last_fc_ff;
   logic                        taken;

   assign taken = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         sat_ff  <= 1'b0;
      end else if (taken) begin
         seen_ff <= 1'b1;
         sat_ff  <= sat_ff || stamp_saturated;
      end
   end

   always_ff @(posedge clock) begin
      if (taken) begin
         last_fc_ff <= fault_count;
      end
   end

   `LPR_ASSERT_IMP(a_hit_no_evict, clock, reset, rsp_valid && hit, !evicted_valid, "hit with eviction")
   `LPR_ASSERT_IMP(a_evict_zero, clock, reset, rsp_valid && !evicted_valid, evicted_page == '0, "evicted page not zero")
   `LPR_ASSERT_IMP(a_sat_sticky, clock, reset, rsp_valid && sat_ff, stamp_saturated, "stamp saturation dropped")
   `LPR_ASSERT_IMP(a_hit_count, clock, reset, rsp_valid && seen_ff && hit, fault_count == last_fc_ff, "fault count moved on hit")
   `LPR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result word dropped")

endmodule

bind lru_page_replacement_core lpr_checker u_lpr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .hit             (rsp_port.hit),
   .evicted_valid   (rsp_port.evicted_valid),
   .evicted_page    (rsp_port.evicted_page),
   .fault_count     (rsp_port.fault_count),
   .stamp_saturated (rsp_port.stamp_saturated)
);

[dv/lru_page_replacement_core_test.sv]
// Self-checking test of lru_page_replacement_core: page references in, placement words out.
// A scoreboard class predicts every placement word; plain tasks drive the request and
// frame-count ports, a free-running process drives result ready. Depends on lpr_pkg, lpr_if and the core itself.
module lru_page_replacement_core_test;

   localparam int SLOTS       = lpr_pkg::FRAMES_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_WORDS = 138;
   localparam int CMP_W       = lpr_pkg::COUNT_W;

   typedef struct packed {
      logic                            hit;
      logic [lpr_pkg::FRAME_IDX_W-1:0] frame_index;
      logic                            evicted_valid;
      logic [lpr_pkg::PAGE_W-1:0]      evicted_page;
      logic [lpr_pkg::COUNT_W-1:0]     fault_count;
      logic                            stamp_saturated;
   } placement_type;

   class replacement_tracker_type;
      logic [lpr_pkg::PAGE_W-1:0]  held_page [SLOTS];
      bit                          in_use    [SLOTS];
      logic [lpr_pkg::STAMP_W-1:0] last_use  [SLOTS];
      logic [lpr_pkg::STAMP_W-1:0] ref_clock;
      logic [lpr_pkg::COUNT_W-1:0] fault_total;
      logic [lpr_pkg::CSR_W-1:0]   frame_limit;
      placement_type               pending_placements [$];
      int                          mismatches;

      function new();
         foreach (in_use[i]) begin
            held_page[i] = '0;
            in_use[i]    = 1'b0;
            last_use[i]  = '0;
         end
         ref_clock   = '0;
         fault_total = '0;
         frame_limit = lpr_pkg::CSR_RESET;
         mismatches  = 0;
      endfunction

      function void set_frame_limit(logic [lpr_pkg::CSR_W-1:0] count);
         frame_limit = count;
      endfunction

      function int pending_count();
         return pending_placements.size();
      endfunction

      function void note_reference(logic [lpr_pkg::PAGE_W-1:0] page);
         int unsigned                 active;
         int unsigned                 slot;
         bit                          found;
         logic [lpr_pkg::STAMP_W-1:0] oldest;
         placement_type               want;
         active = (frame_limit == 0) ? 1 : (frame_limit > SLOTS) ? SLOTS : frame_limit;
         if (ref_clock != lpr_pkg::STAMP_MAX) ref_clock++;
         found = 1'b0;
         slot  = 0;
         want  = '0;
         for (int i = 0; i < active; i++) begin
            if (!found && in_use[i] && held_page[i] == page) begin
               found = 1'b1;
               slot  = i;
            end
         end
         if (!found) begin
            oldest = last_use[0];
            for (int i = 0; i < active; i++) begin
               if (last_use[i] <= oldest) begin
                  oldest = last_use[i];
                  slot   = i;
               end
            end
            if (fault_total != lpr_pkg::COUNT_MAX) fault_total++;
            if (in_use[slot]) begin
               want.evicted_valid = 1'b1;
               want.evicted_page  = held_page[slot];
            end
            held_page[slot] = page;
            in_use[slot]    = 1'b1;
         end
         last_use[slot]       = ref_clock;
         want.hit             = found;
         want.frame_index     = lpr_pkg::FRAME_IDX_W'(slot);
         want.fault_count     = fault_total;
         want.stamp_saturated = (ref_clock == lpr_pkg::STAMP_MAX);
         pending_placements.push_back(want);
      endfunction

      function void compare_field(string field, logic [lpr_pkg::COUNT_W-1:0] want,
                                  logic [lpr_pkg::COUNT_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(placement_type got);
         placement_type want;
         if (pending_placements.size() == 0) begin
            $error("placement word with no reference outstanding");
            mismatches++;
            return;
         end
         want = pending_placements.pop_front();
         compare_field("hit", CMP_W'(want.hit), CMP_W'(got.hit));
         compare_field("frame_index", CMP_W'(want.frame_index), CMP_W'(got.frame_index));
         compare_field("evicted_valid", CMP_W'(want.evicted_valid),
                       CMP_W'(got.evicted_valid));
         compare_field("evicted_page", CMP_W'(want.evicted_page), CMP_W'(got.evicted_page));
         compare_field("fault_count", want.fault_count, got.fault_count);
         compare_field("stamp_saturated", CMP_W'(want.stamp_saturated),
                       CMP_W'(got.stamp_saturated));
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_we;
   logic [lpr_pkg::CSR_W-1:0] csr_wdata;

   lpr_req_if req_ch ();
   lpr_rsp_if rsp_ch ();

   lru_page_replacement_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_port  (req_ch),
      .rsp_port  (rsp_ch)
   );

   replacement_tracker_type track = new();

   int unsigned words_in      = 0;
   int unsigned stall_cycles  = 0;
   bit          idle_on       = 1'b1;

   logic [lpr_pkg::PAGE_W-1:0] opening [14] = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04,
                                                8'h05, 8'h06, 8'h00, 8'hFF, 8'h80, 8'hAA,
                                                8'h55, 8'h33};
   logic [lpr_pkg::CSR_W-1:0]  phase_limits [10] = '{4'd3, 4'd5, 4'd15, 4'd2, 4'd0,
                                                     4'd7, 4'd4, 4'd6, 4'd1, 4'd8};

   always #5 clock = ~clock;

   always @(posedge clock) begin
      placement_type seen;
      bit            moved;
      moved = 1'b0;
      if (!reset && req_ch.valid && req_ch.ready) begin
         track.note_reference(req_ch.page_id);
         words_in++;
         moved = 1'b1;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen.hit             = rsp_ch.hit;
         seen.frame_index     = rsp_ch.frame_index;
         seen.evicted_valid   = rsp_ch.evicted_valid;
         seen.evicted_page    = rsp_ch.evicted_page;
         seen.fault_count     = rsp_ch.fault_count;
         seen.stamp_saturated = rsp_ch.stamp_saturated;
         track.check_result(seen);
         moved = 1'b1;
      end
      if (reset || moved) stall_cycles = 0;
      else stall_cycles++;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_reference(input logic [lpr_pkg::PAGE_W-1:0] page);
      int unsigned target;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      target = words_in + 1;
      req_ch.valid   <= 1'b1;
      req_ch.page_id <= page;
      do @(negedge clock); while (words_in != target);
   endtask

   task automatic settle_idle();
      req_ch.valid <= 1'b0;
      while (track.pending_count() != 0) @(negedge clock);
      repeat (SLOTS + 3) @(negedge clock);
   endtask

   task automatic write_frame_count(input logic [lpr_pkg::CSR_W-1:0] count);
      settle_idle();
      csr_we    <= 1'b1;
      csr_wdata <= count;
      @(negedge clock);
      csr_we <= 1'b0;
      track.set_frame_limit(count);
   endtask

   initial begin
      logic [lpr_pkg::PAGE_W-1:0] page;
      logic [lpr_pkg::PAGE_W-1:0] base;
      int unsigned                spread;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.page_id = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill, hit, evict LRU, then park one page in two frames via a shrunk frame count
      foreach (opening[k]) send_reference(opening[k]);
      write_frame_count(4'd1);
      send_reference(8'h33);
      write_frame_count(4'd15);
      send_reference(8'h33);
      write_frame_count(4'd0);
      send_reference(8'hF0);
      send_reference(8'hF0);

      foreach (phase_limits[p]) begin
         write_frame_count(phase_limits[p]);
         idle_on = (p != $size(phase_limits) - 1) && (p % 3 != 1);
         spread  = (phase_limits[p] == 0) ? 4 :
                   (phase_limits[p] > SLOTS) ? SLOTS + 3 : phase_limits[p] + 3;
         base    = lpr_pkg::PAGE_W'($urandom_range(0, 255));
         repeat (PHASE_WORDS) begin
            if ($urandom_range(0, 99) < 85) begin
               page = base + lpr_pkg::PAGE_W'($urandom_range(0, spread));
            end else begin
               page = lpr_pkg::PAGE_W'($urandom_range(0, 255));
            end
            send_reference(page);
         end
      end

      settle_idle();
      if (track.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

[lru_page_replacement_core.f]
+incdir+sv
sv/lpr_pkg.sv
sv/lpr_if.sv
sv/lpr_cell.sv
sv/lru_page_replacement_core.sv
sv/lpr_checker.sv
dv/lru_page_replacement_core_test.sv
